FILE: design/ple_pkg.sv
package ple_pkg;

    localparam int CAPACITY = 16;

    localparam logic signed [31:0] FAIL_ELEMENT = -32'sd999;

    typedef enum logic [1:0] {
        CMD_GET    = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [4:0]         position;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] element;
        logic [4:0]         length;
    } t_rsp;

    // shift controls broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctrl;

endpackage

FILE: design/ple_cell.sv
module ple_cell #(
    parameter int IW    = 4,
    parameter int INDEX = 0
) (
    input  logic                    i_clk,
    input  ple_pkg::t_cell_ctrl     i_ctrl,
    input  logic [IW-1:0]           i_idx,
    input  logic signed [31:0]      i_below,
    input  logic signed [31:0]      i_above,
    input  logic signed [31:0]      i_value,
    output logic signed [31:0]      o_value,
    output logic signed [31:0]      o_rd
);
    import ple_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic signed [31:0] r_value;
    logic signed [31:0] n_value;
    logic               hit;
    logic               after;

    assign hit   = (i_idx == MY_IDX);
    assign after = (MY_IDX > i_idx);

    always_comb begin
        n_value = r_value;
        if (i_ctrl.ins) begin
            if (hit) begin
                n_value = i_value;
            end else if (after) begin
                n_value = i_below;
            end
        end else if (i_ctrl.del) begin
            if (hit || after) begin
                n_value = i_above;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    // read port: only the addressed cell drives nonzero, top ORs them
    assign o_rd    = hit ? r_value : '0;

endmodule

FILE: design/positional_list_engine_top.sv
// channel | direction | handshake                | payload
// in      | input     | i_in_valid / o_in_stall  | i_in_data  (cmd, position, value)
// out     | output    | o_out_valid / i_out_stall| o_out_data (status, element, length)
//
// One request per cycle unless the output is held: each transfer is decoded,
// the cell chain shifts (insert or delete at any position) and the result is
// registered in the same cycle, so it appears in the cycle after its transfer.
// The single output register sets the rate; a new input transfer is taken
// while the held result leaves. Input stalls only when the output is held.
// Reset (synchronous, active low) clears the length and the output valid;
// cell contents stay as they are and are never read beyond the length.
module positional_list_engine_top #(
    parameter int CAPACITY = ple_pkg::CAPACITY
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  ple_pkg::t_req  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output ple_pkg::t_rsp  o_out_data
);
    import ple_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (IW > 5) ? IW : 5;
    localparam int MW = ((CW > 5) ? CW : 5) + 1;
    localparam logic [MW-1:0] CAP_M = MW'(CAPACITY);

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_out_valid;
    t_rsp               r_out_data;
    t_rsp               n_out_data;

    logic               in_fire;
    logic [MW-1:0]      pos_m;
    logic [MW-1:0]      cnt_m;
    logic [MW-1:0]      len_m;
    logic [PW-1:0]      idx_full;
    logic [IW-1:0]      idx;
    logic               do_ins;
    logic               do_del;
    t_cell_ctrl         ctrl;
    logic signed [31:0] rd_data;

    logic signed [31:0] cell_val [CAPACITY];
    logic signed [31:0] cell_rd  [CAPACITY];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_fire    = i_in_valid && !o_in_stall;

    assign pos_m    = MW'(i_in_data.position);
    assign cnt_m    = MW'(r_count);
    assign idx_full = PW'(i_in_data.position) - PW'(1);
    assign idx      = idx_full[IW-1:0];

    always_comb begin
        n_count            = r_count;
        do_ins             = 1'b0;
        do_del             = 1'b0;
        n_out_data.status  = ST_RANGE;
        n_out_data.element = '0;
        unique case (i_in_data.cmd)
            CMD_GET: begin
                if (pos_m != '0 && pos_m <= cnt_m) begin
                    n_out_data.status  = ST_OK;
                    n_out_data.element = rd_data;
                end else begin
                    n_out_data.element = FAIL_ELEMENT;
                end
            end
            CMD_INSERT: begin
                // position checked before fullness
                if (pos_m != '0 && pos_m <= cnt_m + MW'(1)) begin
                    if (cnt_m >= CAP_M) begin
                        n_out_data.status = ST_FULL;
                    end else begin
                        n_out_data.status = ST_OK;
                        do_ins            = 1'b1;
                        n_count           = r_count + CW'(1);
                    end
                end
            end
            CMD_DELETE: begin
                if (pos_m != '0 && pos_m <= cnt_m) begin
                    n_out_data.status  = ST_OK;
                    n_out_data.element = rd_data;
                    do_del             = 1'b1;
                    n_count            = r_count - CW'(1);
                end
            end
            default: begin
            end
        endcase
        len_m             = MW'(n_count);
        n_out_data.length = len_m[4:0];
    end

    assign ctrl.ins = in_fire && do_ins;
    assign ctrl.del = in_fire && do_del;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [31:0] below;
            logic signed [31:0] above;
            if (g == 0) begin : g_first
                assign below = cell_val[g];
            end else begin : g_mid_lo
                assign below = cell_val[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign above = cell_val[g];
            end else begin : g_mid_hi
                assign above = cell_val[g+1];
            end
            ple_cell #(
                .IW    (IW),
                .INDEX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (ctrl),
                .i_idx   (idx),
                .i_below (below),
                .i_above (above),
                .i_value (i_in_data.value),
                .o_value (cell_val[g]),
                .o_rd    (cell_rd[g])
            );
        end
    endgenerate

    always_comb begin
        rd_data = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_data = rd_data | cell_rd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: verif/ple_response_checker.sv
`timescale 1ns / 1ps
module ple_response_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  ple_pkg::t_req  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  ple_pkg::t_rsp  i_out_data,
    output int             o_fail_count,
    output int             o_pending
);
    import ple_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic signed [31:0] list_cells [CAPACITY];
    int                 list_len = 0;
    t_rsp               expected_rsps [$];
    int                 fail_total = 0;

    // Applies one request to the shadow list and returns the response it yields.
    function automatic t_rsp apply_request(input t_req req);
        t_rsp rsp;
        int   pos;
        pos         = int'(req.position);
        rsp.status  = ST_RANGE;
        rsp.element = '0;
        case (req.cmd)
            CMD_GET: begin
                if (pos >= 1 && pos <= list_len) begin
                    rsp.status  = ST_OK;
                    rsp.element = list_cells[pos - 1];
                end else begin
                    rsp.element = FAIL_ELEMENT;
                end
            end
            CMD_INSERT: begin
                // position is checked before fullness
                if (pos >= 1 && pos <= list_len + 1) begin
                    if (list_len >= CAPACITY) begin
                        rsp.status = ST_FULL;
                    end else begin
                        for (int k = list_len; k > pos - 1; k--) begin
                            list_cells[k] = list_cells[k - 1];
                        end
                        list_cells[pos - 1] = req.value;
                        list_len++;
                        rsp.status = ST_OK;
                    end
                end
            end
            CMD_DELETE: begin
                if (pos >= 1 && pos <= list_len) begin
                    rsp.element = list_cells[pos - 1];
                    for (int k = pos - 1; k + 1 < list_len; k++) begin
                        list_cells[k] = list_cells[k + 1];
                    end
                    list_len--;
                    rsp.status = ST_OK;
                end
            end
            default: ;
        endcase
        rsp.length = 5'(list_len);
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            list_len = 0;
            expected_rsps.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_rsps.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT) begin
                        $display("%0t: unexpected response status=%0d element=%0d length=%0d",
                                 $realtime, i_out_data.status, i_out_data.element,
                                 i_out_data.length);
                    end
                end else begin
                    want = expected_rsps.pop_front();
                    if (i_out_data.status !== want.status
                            || i_out_data.element !== want.element
                            || i_out_data.length !== want.length) begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT) begin
                            $display("%0t: response mismatch exp status=%0d element=%0d length=%0d",
                                     $realtime, want.status, want.element, want.length);
                            $display("%0t:                   got status=%0d element=%0d length=%0d",
                                     $realtime, i_out_data.status, i_out_data.element,
                                     i_out_data.length);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_rsps.push_back(apply_request(i_in_data));
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_rsps.size();
    end

endmodule

FILE: verif/tb_positional_list_engine_top.sv
`timescale 1ns / 1ps
module tb_positional_list_engine_top;
    import ple_pkg::*;

    localparam int          RANDOM_ITEMS = 1750;
    localparam int          QUIET_LIMIT  = 1000;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_req in_data   = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_rsp out_data;
    int   fail_count;
    int   pending;

    int fill_level   = 0;
    int burst_left   = 1;
    int quiet_cycles = 0;
    int stall_run    = 0;
    int stall_mode   = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    positional_list_engine_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    ple_response_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver: runs of free flow, light stall, heavy stall and solid stall
    always @(posedge clk) begin
        if (stall_run == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_run  <= $urandom_range(4, 40);
        end else begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= 1'b1;
        endcase
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_transfer(input t_req req);
        in_data  <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic issue_request(input logic [1:0] cmd, input int pos, input logic [31:0] value);
        t_req req;
        int   gap;
        req.cmd      = cmd;
        req.position = 5'(pos);
        req.value    = value;
        send_transfer(req);
        // rough length tracking, only to aim positions
        if (cmd == CMD_INSERT && pos >= 1 && pos <= fill_level + 1 && fill_level < CAPACITY) begin
            fill_level++;
        end else if (cmd == CMD_DELETE && pos >= 1 && pos <= fill_level) begin
            fill_level--;
        end
        burst_left--;
        if (burst_left <= 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial begin
        logic [1:0]  cmd;
        int          pos;
        logic [31:0] value;
        int          pick;
        int          mode;
        int          ins_pct;
        int          del_pct;
        int          top_pos;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every command out of range
        issue_request(CMD_GET,    1, 32'h0);
        issue_request(CMD_GET,    0, 32'h0);
        issue_request(CMD_DELETE, 1, 32'h0);
        issue_request(CMD_INSERT, 2, 32'h1234_5678);
        issue_request(CMD_INSERT, 0, 32'h1234_5678);
        issue_request(CMD_UNUSED, 1, 32'hdead_beef);
        // build: front, end, front, middle
        issue_request(CMD_INSERT, 1, 32'h8000_0000);
        issue_request(CMD_INSERT, 2, 32'h7fff_ffff);
        issue_request(CMD_INSERT, 1, 32'hffff_ffff);
        issue_request(CMD_INSERT, 2, 32'h0);
        issue_request(CMD_GET,    1, 32'h0);
        issue_request(CMD_GET,    4, 32'h0);
        issue_request(CMD_GET,    5, 32'h0);
        issue_request(CMD_GET,   31, 32'h0);
        issue_request(CMD_INSERT, 6, 32'h5555_5555);
        issue_request(CMD_DELETE, 2, 32'h0);
        issue_request(CMD_DELETE, 3, 32'h0);
        issue_request(CMD_DELETE, 4, 32'h0);
        issue_request(CMD_DELETE, 0, 32'h0);
        issue_request(CMD_UNUSED, 0, 32'h0);

        mode = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // 0 grows toward full, 1 drains toward empty, 2 mixed
            if ($urandom_range(0, 39) == 0) mode = $urandom_range(0, 2);
            case (mode)
                0:       begin ins_pct = 65; del_pct = 15; end
                1:       begin ins_pct = 15; del_pct = 65; end
                default: begin ins_pct = 35; del_pct = 30; end
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                cmd = CMD_UNUSED;
            end else if (pick < 2 + ins_pct) begin
                cmd = CMD_INSERT;
            end else if (pick < 2 + ins_pct + del_pct) begin
                cmd = CMD_DELETE;
            end else begin
                cmd = CMD_GET;
            end
            top_pos = (cmd == CMD_INSERT) ? fill_level + 1 : fill_level;
            if ($urandom_range(0, 4) == 0 || top_pos < 1) begin
                pos = $urandom_range(0, 31);
            end else begin
                pos = $urandom_range(1, top_pos);
            end
            case ($urandom_range(0, 7))
                0:       value = 32'h8000_0000;
                1:       value = 32'h7fff_ffff;
                2:       value = FAIL_ELEMENT;
                default: value = $urandom;
            endcase
            issue_request(cmd, pos, value);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: positional_list_engine_top.f
design/ple_pkg.sv
design/ple_cell.sv
design/positional_list_engine_top.sv
verif/ple_response_checker.sv
verif/tb_positional_list_engine_top.sv
